// File: hw/rtl/tcw_pkg.sv
// Shared types, codes and constants of the text console writer.
package tcw_pkg;

    // Field widths of the item and result channels.
    localparam int ACTION_W    = 2;
    localparam int CHAR_W      = 8;
    localparam int COLUMN_W    = 7;
    localparam int ROW_FIELD_W = 5;
    localparam int COLOR_W     = 4;
    localparam int INDEX_W     = 11;
    localparam int POS_W       = 11;
    localparam int ATTR_W      = 8;
    localparam int CELL_W      = CHAR_W + ATTR_W;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = COLOR_W;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_COLOR  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAPER_COLOR = 1'b1;

    // Reset values of the color registers.
    localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET  = 4'd15;
    localparam logic [COLOR_W-1:0] PAPER_COLOR_RESET = 4'd0;

    // Character codes with a special meaning.
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

    // Default screen geometry.
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Item actions.
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_SET   = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic sweep_step;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_needed;
        logic sweep_last;
        logic out_free;
    } status_t;

endpackage

// File: hw/rtl/tcw_req_if.sv
// Item channel of the text console writer: valid, ready and the item fields.
interface tcw_req_if;
    logic                               valid;
    logic                               ready;
    logic [tcw_pkg::ACTION_W-1:0]       action;
    logic [tcw_pkg::CHAR_W-1:0]         char_code;
    logic [tcw_pkg::COLUMN_W-1:0]       column;
    logic [tcw_pkg::ROW_FIELD_W-1:0]    row;
    logic [tcw_pkg::COLOR_W-1:0]        fill_color;
    logic [tcw_pkg::INDEX_W-1:0]        cell_index;

    modport source (
        output valid, action, char_code, column, row, fill_color, cell_index,
        input  ready
    );

    modport sink (
        input  valid, action, char_code, column, row, fill_color, cell_index,
        output ready
    );
endinterface

// File: hw/rtl/tcw_resp_if.sv
// Result channel of the text console writer: valid, ready and the result fields.
interface tcw_resp_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::POS_W-1:0]    cursor_position;
    logic [tcw_pkg::CHAR_W-1:0]   cell_char;
    logic [tcw_pkg::ATTR_W-1:0]   cell_attr;

    modport source (
        output valid, cursor_position, cell_char, cell_attr,
        input  ready
    );

    modport sink (
        input  valid, cursor_position, cell_char, cell_attr,
        output ready
    );
endinterface

// File: hw/rtl/text_console_writer.sv
// Text console writer: a COLUMNS x ROWS cell store with a cursor, driven by items.
// After an item is accepted, the EXEC state runs it and the FINISH state registers its
// result; a scroll or a clear screen puts a sweep of all COLUMNS*ROWS cells between them,
// one cell per cycle through the single write port of the cell store.
// The next item may be taken as the result goes out, when the result register is free.
// Reset: a clearing pass over all COLUMNS*ROWS cells zeroes the store; no item is taken
// meanwhile. Colors reset to white text on black paper, the cursor to the origin.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tcw_req_if.sink                          req,
    tcw_resp_if.source                       resp,
    input  logic                             cfg_we,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tcw_pkg::cmd_t    cmd;
    tcw_pkg::status_t status;

    // Controller: sequencing and the item handshake.
    tcw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (req.valid),
        .item_ready (req.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Datapath: store, cursor and result register.
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .action          (req.action),
        .char_code       (req.char_code),
        .column          (req.column),
        .row             (req.row),
        .fill_color      (req.fill_color),
        .cell_index      (req.cell_index),
        .out_valid       (resp.valid),
        .out_ready       (resp.ready),
        .cursor_position (resp.cursor_position),
        .cell_char       (resp.cell_char),
        .cell_attr       (resp.cell_attr)
    );

endmodule

// File: hw/rtl/tcw_ctrl.sv
// Controller state machine of the text console writer.
module tcw_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  tcw_pkg::status_t status,
    output tcw_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state, handshake and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        item_ready     = 1'b0;
        cmd.load_item  = 1'b0;
        cmd.exec       = 1'b0;
        cmd.sweep_step = 1'b0;
        cmd.finish     = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_ready    = 1'b1;
                cmd.load_item = item_valid;
                if (item_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.sweep_needed)
                begin
                    state_next = ST_SWEEP;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // The result goes out and the next item may enter in the same cycle.
                if (status.out_free)
                begin
                    cmd.finish    = 1'b1;
                    item_ready    = 1'b1;
                    cmd.load_item = item_valid;
                    if (item_valid)
                    begin
                        state_next = ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing pass over the cell store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/tcw_datapath.sv
// Datapath of the text console writer: cell store, cursor, sweep counter and result register.
module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tcw_pkg::cmd_t                      cmd,
    output tcw_pkg::status_t                   status,
    input  logic                               cfg_we,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [tcw_pkg::ACTION_W-1:0]       action,
    input  logic [tcw_pkg::CHAR_W-1:0]         char_code,
    input  logic [tcw_pkg::COLUMN_W-1:0]       column,
    input  logic [tcw_pkg::ROW_FIELD_W-1:0]    row,
    input  logic [tcw_pkg::COLOR_W-1:0]        fill_color,
    input  logic [tcw_pkg::INDEX_W-1:0]        cell_index,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [tcw_pkg::POS_W-1:0]          cursor_position,
    output logic [tcw_pkg::CHAR_W-1:0]         cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]         cell_attr
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W  = $clog2(ROWS);

    // Cell store.
    logic [tcw_pkg::CELL_W-1:0] mem [CELLS];

    // Configuration registers.
    logic [tcw_pkg::COLOR_W-1:0] text_color_reg;
    logic [tcw_pkg::COLOR_W-1:0] paper_color_reg;

    // Latched item.
    tcw_pkg::action_t                  action_reg;
    logic [tcw_pkg::CHAR_W-1:0]        char_reg;
    logic [tcw_pkg::COLUMN_W-1:0]      column_reg;
    logic [tcw_pkg::ROW_FIELD_W-1:0]   row_reg;
    logic [tcw_pkg::COLOR_W-1:0]       fill_reg;
    logic [tcw_pkg::INDEX_W-1:0]       index_reg;

    // Cursor.
    logic [COL_W-1:0] cursor_col_reg;
    logic [COL_W-1:0] cursor_col_next;
    logic [ROW_W-1:0] cursor_row_reg;
    logic [ROW_W-1:0] cursor_row_next;

    // Sweep control for clearing and scrolling.
    logic [ADDR_W-1:0]          sweep_cnt_reg;
    logic [ADDR_W-1:0]          sweep_cnt_next;
    logic                       copy_reg;
    logic                       copy_next;
    logic [tcw_pkg::CELL_W-1:0] blank_reg;
    logic [tcw_pkg::CELL_W-1:0] blank_next;

    // Write stage in front of the store.
    logic                       wr_en_reg;
    logic                       wr_en_next;
    logic [ADDR_W-1:0]          wr_addr_reg;
    logic [ADDR_W-1:0]          wr_addr_next;
    logic [tcw_pkg::CELL_W-1:0] wr_data_reg;
    logic [tcw_pkg::CELL_W-1:0] wr_data_next;
    logic                       wr_from_rd_reg;
    logic                       wr_from_rd_next;
    logic [tcw_pkg::CELL_W-1:0] wr_value;

    // Read port.
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic [tcw_pkg::CELL_W-1:0] rd_data_reg;
    logic                       rd_ok_reg;
    logic                       rd_ok_next;

    // Result register.
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [tcw_pkg::POS_W-1:0]   pos_out_reg;
    logic [tcw_pkg::CHAR_W-1:0]  char_out_reg;
    logic [tcw_pkg::ATTR_W-1:0]  attr_out_reg;

    // Helper terms.
    logic [ADDR_W-1:0] cursor_pos;
    logic              col_last;
    logic              row_last;
    logic              line_break;
    logic              index_in_range;
    logic              copying;
    logic              sweep_needed;

    assign cursor_pos = ADDR_W'(cursor_row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_col_reg);
    assign col_last   = (cursor_col_reg == COL_W'(COLUMNS - 1));
    assign row_last   = (cursor_row_reg == ROW_W'(ROWS - 1));
    assign line_break = (char_reg == tcw_pkg::NEWLINE_CODE) || col_last;
    assign index_in_range = (32'(index_reg) < 32'(CELLS));
    assign copying    = copy_reg && (sweep_cnt_reg < ADDR_W'(CELLS - COLUMNS));
    assign wr_value   = wr_from_rd_reg ? rd_data_reg : wr_data_reg;

    // Item execution and sweep stepping.
    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        copy_next       = copy_reg;
        blank_next      = blank_reg;
        wr_en_next      = 1'b0;
        wr_addr_next    = wr_addr_reg;
        wr_data_next    = wr_data_reg;
        wr_from_rd_next = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = sweep_cnt_reg;
        rd_ok_next      = rd_ok_reg;
        sweep_needed    = 1'b0;

        if (cmd.exec)
        begin
            rd_ok_next = 1'b0;
            unique case (action_reg)
                tcw_pkg::ACT_PUT:
                begin
                    // Any character but a newline lands under the cursor.
                    if (char_reg != tcw_pkg::NEWLINE_CODE)
                    begin
                        wr_en_next   = 1'b1;
                        wr_addr_next = cursor_pos;
                        wr_data_next = {paper_color_reg, text_color_reg, char_reg};
                    end
                    if (line_break)
                    begin
                        cursor_col_next = '0;
                        if (row_last)
                        begin
                            sweep_needed = 1'b1;
                            copy_next    = 1'b1;
                            blank_next   = {paper_color_reg, text_color_reg,
                                            tcw_pkg::SPACE_CODE};
                        end
                        else
                        begin
                            cursor_row_next = cursor_row_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        cursor_col_next = cursor_col_reg + COL_W'(1);
                    end
                end
                tcw_pkg::ACT_CLEAR:
                begin
                    sweep_needed = 1'b1;
                    copy_next    = 1'b0;
                    blank_next   = {fill_reg, text_color_reg, tcw_pkg::SPACE_CODE};
                end
                tcw_pkg::ACT_SET:
                begin
                    if (32'(column_reg) >= 32'(COLUMNS))
                    begin
                        cursor_col_next = COL_W'(COLUMNS - 1);
                    end
                    else
                    begin
                        cursor_col_next = COL_W'(column_reg);
                    end
                    if (32'(row_reg) >= 32'(ROWS))
                    begin
                        cursor_row_next = ROW_W'(ROWS - 1);
                    end
                    else
                    begin
                        cursor_row_next = ROW_W'(row_reg);
                    end
                end
                tcw_pkg::ACT_READ:
                begin
                    rd_ok_next = index_in_range;
                    rd_en      = index_in_range;
                    rd_addr    = ADDR_W'(index_reg);
                end
                default:
                begin
                    rd_ok_next = 1'b0;
                end
            endcase
        end

        // One cell per cycle: copy from one row below, or write the blank cell.
        if (cmd.sweep_step)
        begin
            rd_en           = copying;
            rd_addr         = sweep_cnt_reg + ADDR_W'(COLUMNS);
            wr_en_next      = 1'b1;
            wr_addr_next    = sweep_cnt_reg;
            wr_data_next    = blank_reg;
            wr_from_rd_next = copying;
            if (status.sweep_last)
            begin
                sweep_cnt_next = '0;
            end
            else
            begin
                sweep_cnt_next = sweep_cnt_reg + ADDR_W'(1);
            end
        end
    end

    assign status.sweep_needed = sweep_needed;
    assign status.sweep_last   = (sweep_cnt_reg == ADDR_W'(CELLS - 1));
    assign status.out_free     = !out_valid_reg || out_ready;

    // Result valid flag.
    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Cell store with a registered read; a write to the address being read is forwarded.
    always_ff @(posedge clk)
    begin
        if (wr_en_reg)
        begin
            mem[wr_addr_reg] <= wr_value;
        end
        if (rd_en)
        begin
            if (wr_en_reg && (wr_addr_reg == rd_addr))
            begin
                rd_data_reg <= wr_value;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    // Control registers. After reset the blank cell is zero for the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg  <= tcw_pkg::TEXT_COLOR_RESET;
            paper_color_reg <= tcw_pkg::PAPER_COLOR_RESET;
            cursor_col_reg  <= '0;
            cursor_row_reg  <= '0;
            sweep_cnt_reg   <= '0;
            copy_reg        <= 1'b0;
            blank_reg       <= '0;
            wr_en_reg       <= 1'b0;
            wr_from_rd_reg  <= 1'b0;
            rd_ok_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tcw_pkg::CFG_TEXT_COLOR:  text_color_reg  <= cfg_data;
                    tcw_pkg::CFG_PAPER_COLOR: paper_color_reg <= cfg_data;
                    default:                  text_color_reg  <= text_color_reg;
                endcase
            end
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            copy_reg       <= copy_next;
            blank_reg      <= blank_next;
            wr_en_reg      <= wr_en_next;
            wr_from_rd_reg <= wr_from_rd_next;
            rd_ok_reg      <= rd_ok_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: latched item, write stage address and data, result fields.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg <= tcw_pkg::action_t'(action);
            char_reg   <= char_code;
            column_reg <= column;
            row_reg    <= row;
            fill_reg   <= fill_color;
            index_reg  <= cell_index;
        end
        wr_addr_reg <= wr_addr_next;
        wr_data_reg <= wr_data_next;
        if (cmd.finish)
        begin
            pos_out_reg <= tcw_pkg::POS_W'(cursor_pos);
            if (rd_ok_reg)
            begin
                char_out_reg <= rd_data_reg[tcw_pkg::CHAR_W-1:0];
                attr_out_reg <= rd_data_reg[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
            end
            else
            begin
                char_out_reg <= '0;
                attr_out_reg <= '0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign cursor_position = pos_out_reg;
    assign cell_char       = char_out_reg;
    assign cell_attr       = attr_out_reg;

endmodule
